/* rtl/odlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odlp_pkg
// Shared types, codes and helpers of the object directory listing parser:
// transaction structs, parse phase codes, result kinds and status codes.
// ----------------------------------------------------------------------------
package odlp_pkg;

    // Entry framing limits
    localparam logic [15:0] ENTRY_MIN_LEN = 16'd13;
    localparam logic [15:0] ENTRY_MAX_LEN = 16'd172;
    localparam logic [7:0]  NAME_MAX_LEN  = 8'd120;
    localparam logic [2:0]  ID_LEN        = 3'd6;
    localparam logic [2:0]  TYPE_LEN      = 3'd2;
    localparam logic [2:0]  SIZE_LEN      = 3'd4;
    localparam logic [2:0]  DATE_LEN      = 3'd7;

    // Parse phases
    localparam logic [3:0] PH_LEN_LO  = 4'd0;
    localparam logic [3:0] PH_LEN_HI  = 4'd1;
    localparam logic [3:0] PH_ID      = 4'd2;
    localparam logic [3:0] PH_NAMELEN = 4'd3;
    localparam logic [3:0] PH_NAME    = 4'd4;
    localparam logic [3:0] PH_FLAGS   = 4'd5;
    localparam logic [3:0] PH_TYPE    = 4'd6;
    localparam logic [3:0] PH_CUR     = 4'd7;
    localparam logic [3:0] PH_ALLOC   = 4'd8;
    localparam logic [3:0] PH_FIRST   = 4'd9;
    localparam logic [3:0] PH_LAST    = 4'd10;
    localparam logic [3:0] PH_PROPS   = 4'd11;
    localparam logic [3:0] PH_SKIP    = 4'd12;

    // Result kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEN  = 3'd1;
    localparam logic [2:0] ST_BAD_NAME = 3'd2;
    localparam logic [2:0] ST_OVERRUN  = 3'd3;
    localparam logic [2:0] ST_UUID128  = 3'd4;
    localparam logic [2:0] ST_TRUNC    = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_char;
        logic [47:0] object_id;
        logic [15:0] object_type;
        logic [31:0] used_size;
        logic        has_used_size;
        logic [31:0] capacity;
        logic        has_capacity;
        logic [31:0] object_properties;
        logic [6:0]  name_size;
        logic [2:0]  status;
    } t_out_item;

    // Pick the next optional field present after the given phase
    function automatic logic [3:0] next_optional(input logic [3:0] from,
                                                 input logic [7:0] flags);
        logic [3:0] res;
        logic       found;
        res   = PH_SKIP;
        found = 1'b0;
        for (int p = int'(PH_CUR); p <= int'(PH_PROPS); p++) begin
            if (!found && (4'(p) > from) && flags[p - int'(PH_TYPE)]) begin
                res   = 4'(p);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    // Byte length of an optional field
    function automatic logic [2:0] field_len(input logic [3:0] ph);
        logic [2:0] len;
        if (ph == PH_TYPE) begin
            len = TYPE_LEN;
        end else if (ph == PH_FIRST || ph == PH_LAST) begin
            len = DATE_LEN;
        end else begin
            len = SIZE_LEN;
        end
        return len;
    endfunction

endpackage

/* rtl/odlp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odlp_parser
// Parse state and the single-pass update for one listing byte. Produces up
// to two results per byte: a name byte, record or error first, then the
// done or truncation result of a marked last byte.
// ----------------------------------------------------------------------------
module odlp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  odlp_pkg::t_in_item  i_item,
    output logic [1:0]          o_res_cnt,
    output odlp_pkg::t_out_item o_res0,
    output odlp_pkg::t_out_item o_res1
);

    logic [3:0]  r_phase,      n_phase;
    logic [7:0]  r_ebc,        n_ebc;
    logic [2:0]  r_fbc,        n_fbc;
    logic [7:0]  r_esize,      n_esize;
    logic [7:0]  r_flags,      n_flags;
    logic [6:0]  r_name_rem,   n_name_rem;
    logic [6:0]  r_name_total, n_name_total;
    logic [47:0] r_id,         n_id;
    logic [15:0] r_type,       n_type;
    logic [31:0] r_cur,        n_cur;
    logic [31:0] r_alloc,      n_alloc;
    logic [31:0] r_props,      n_props;
    logic        r_halted,     n_halted;

    logic [7:0]          v_b;
    logic [15:0]         v_len;
    logic [2:0]          v_fbc_inc;
    logic [2:0]          v_err;
    logic                v_fin;
    logic                v_first_vld;
    logic                v_tail_vld;
    odlp_pkg::t_out_item v_first;
    odlp_pkg::t_out_item v_tail;

    // Compute next state and results for the byte in the input register
    always_comb begin
        n_phase      = r_phase;
        n_ebc        = r_ebc;
        n_fbc        = r_fbc;
        n_esize      = r_esize;
        n_flags      = r_flags;
        n_name_rem   = r_name_rem;
        n_name_total = r_name_total;
        n_id         = r_id;
        n_type       = r_type;
        n_cur        = r_cur;
        n_alloc      = r_alloc;
        n_props      = r_props;
        n_halted     = r_halted;
        v_b          = i_item.data_byte;
        v_len        = {v_b, r_esize};
        v_fbc_inc    = r_fbc + 3'd1;
        v_err        = odlp_pkg::ST_OK;
        v_fin        = 1'b0;
        v_first_vld  = 1'b0;
        v_tail_vld   = 1'b0;
        v_first      = '0;
        v_tail       = '0;

        if (i_fire) begin
            if (r_halted) begin
                // Drop bytes until the marked last byte rearms
                if (i_item.last_byte) begin
                    n_phase  = odlp_pkg::PH_LEN_LO;
                    n_ebc    = '0;
                    n_fbc    = '0;
                    n_halted = 1'b0;
                end
            end else begin
                if (r_phase >= odlp_pkg::PH_ID && r_phase <= odlp_pkg::PH_PROPS &&
                    r_ebc >= r_esize) begin
                    v_err = odlp_pkg::ST_OVERRUN;
                end else begin
                    unique case (r_phase) inside
                        odlp_pkg::PH_LEN_LO: begin
                            n_id         = '0;
                            n_type       = '0;
                            n_cur        = '1;
                            n_alloc      = '1;
                            n_props      = '0;
                            n_flags      = '0;
                            n_name_total = '0;
                            n_esize      = v_b;
                            n_ebc        = '0;
                            n_phase      = odlp_pkg::PH_LEN_HI;
                        end
                        odlp_pkg::PH_LEN_HI: begin
                            if (v_len < odlp_pkg::ENTRY_MIN_LEN ||
                                v_len > odlp_pkg::ENTRY_MAX_LEN) begin
                                v_err = odlp_pkg::ST_BAD_LEN;
                            end else begin
                                n_esize = v_len[7:0];
                                n_fbc   = '0;
                                n_phase = odlp_pkg::PH_ID;
                            end
                        end
                        odlp_pkg::PH_ID: begin
                            for (int k = 0; k < 6; k++) begin
                                if (r_fbc == 3'(k)) begin
                                    n_id[8*k +: 8] = r_id[8*k +: 8] | v_b;
                                end
                            end
                            n_fbc = v_fbc_inc;
                            if (v_fbc_inc >= odlp_pkg::ID_LEN) begin
                                n_phase = odlp_pkg::PH_NAMELEN;
                            end
                        end
                        odlp_pkg::PH_NAMELEN: begin
                            if (v_b < 8'd1 || v_b > odlp_pkg::NAME_MAX_LEN) begin
                                v_err = odlp_pkg::ST_BAD_NAME;
                            end else begin
                                n_name_rem   = v_b[6:0];
                                n_name_total = v_b[6:0];
                                n_phase      = odlp_pkg::PH_NAME;
                            end
                        end
                        odlp_pkg::PH_NAME: begin
                            v_first_vld         = 1'b1;
                            v_first.kind        = odlp_pkg::KIND_NAME;
                            v_first.name_char   = v_b;
                            n_name_rem          = r_name_rem - 7'd1;
                            if (n_name_rem == 7'd0) begin
                                n_phase = odlp_pkg::PH_FLAGS;
                            end
                        end
                        odlp_pkg::PH_FLAGS: begin
                            n_flags = v_b;
                            if (v_b[0]) begin
                                v_err = odlp_pkg::ST_UUID128;
                            end else begin
                                n_fbc   = '0;
                                n_phase = odlp_pkg::PH_TYPE;
                            end
                        end
                        [odlp_pkg::PH_TYPE:odlp_pkg::PH_PROPS]: begin
                            // Merge the byte into its field lane
                            if (r_phase == odlp_pkg::PH_TYPE) begin
                                for (int k = 0; k < 2; k++) begin
                                    if (r_fbc == 3'(k)) begin
                                        n_type[8*k +: 8] = r_type[8*k +: 8] | v_b;
                                    end
                                end
                            end else if (r_phase == odlp_pkg::PH_CUR) begin
                                if (r_fbc == 3'd0) begin
                                    n_cur = {24'd0, v_b};
                                end else begin
                                    for (int k = 1; k < 4; k++) begin
                                        if (r_fbc == 3'(k)) begin
                                            n_cur[8*k +: 8] = r_cur[8*k +: 8] | v_b;
                                        end
                                    end
                                end
                            end else if (r_phase == odlp_pkg::PH_ALLOC) begin
                                if (r_fbc == 3'd0) begin
                                    n_alloc = {24'd0, v_b};
                                end else begin
                                    for (int k = 1; k < 4; k++) begin
                                        if (r_fbc == 3'(k)) begin
                                            n_alloc[8*k +: 8] = r_alloc[8*k +: 8] | v_b;
                                        end
                                    end
                                end
                            end else if (r_phase == odlp_pkg::PH_PROPS) begin
                                for (int k = 0; k < 4; k++) begin
                                    if (r_fbc == 3'(k)) begin
                                        n_props[8*k +: 8] = r_props[8*k +: 8] | v_b;
                                    end
                                end
                            end
                            // Advance to the next field present
                            n_fbc = v_fbc_inc;
                            if (v_fbc_inc >= odlp_pkg::field_len(r_phase)) begin
                                n_fbc   = '0;
                                n_phase = odlp_pkg::next_optional(r_phase, r_flags);
                                if (n_phase == odlp_pkg::PH_SKIP) begin
                                    v_fin = 1'b1;
                                end
                            end
                        end
                        default: begin
                            // Skip trailing entry bytes
                        end
                    endcase
                end

                if (v_err == odlp_pkg::ST_OK) begin
                    n_ebc = n_ebc + 8'd1;
                end

                if (v_err != odlp_pkg::ST_OK) begin
                    // Report the error and halt, or rearm on the last byte
                    v_first_vld    = 1'b1;
                    v_first.kind   = odlp_pkg::KIND_ERROR;
                    v_first.status = v_err;
                    if (i_item.last_byte) begin
                        n_phase  = odlp_pkg::PH_LEN_LO;
                        n_ebc    = '0;
                        n_fbc    = '0;
                        n_halted = 1'b0;
                    end else begin
                        n_halted = 1'b1;
                    end
                end else begin
                    if (v_fin) begin
                        v_first_vld               = 1'b1;
                        v_first.kind              = odlp_pkg::KIND_RECORD;
                        v_first.object_id         = n_id;
                        v_first.object_type       = n_type;
                        v_first.used_size         = n_cur;
                        v_first.has_used_size     = n_flags[1];
                        v_first.capacity          = n_alloc;
                        v_first.has_capacity      = n_flags[2];
                        v_first.object_properties = n_props;
                        v_first.name_size         = n_name_total;
                    end
                    if (n_phase == odlp_pkg::PH_SKIP && n_ebc >= n_esize) begin
                        n_phase = odlp_pkg::PH_LEN_LO;
                    end
                    if (i_item.last_byte) begin
                        v_tail_vld = 1'b1;
                        if (n_phase == odlp_pkg::PH_LEN_LO ||
                            n_phase == odlp_pkg::PH_SKIP) begin
                            v_tail.kind = odlp_pkg::KIND_DONE;
                        end else begin
                            v_tail.kind   = odlp_pkg::KIND_ERROR;
                            v_tail.status = odlp_pkg::ST_TRUNC;
                        end
                        n_phase  = odlp_pkg::PH_LEN_LO;
                        n_ebc    = '0;
                        n_fbc    = '0;
                        n_halted = 1'b0;
                    end
                end
            end
        end
    end

    // Pack the results into the first free slots
    always_comb begin
        o_res_cnt = {1'b0, v_first_vld} + {1'b0, v_tail_vld};
        o_res0    = v_first_vld ? v_first : v_tail;
        o_res1    = v_tail;
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= odlp_pkg::PH_LEN_LO;
            r_ebc        <= '0;
            r_fbc        <= '0;
            r_esize      <= '0;
            r_flags      <= '0;
            r_name_rem   <= '0;
            r_name_total <= '0;
            r_id         <= '0;
            r_type       <= '0;
            r_cur        <= '1;
            r_alloc      <= '1;
            r_props      <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_ebc        <= n_ebc;
            r_fbc        <= n_fbc;
            r_esize      <= n_esize;
            r_flags      <= n_flags;
            r_name_rem   <= n_name_rem;
            r_name_total <= n_name_total;
            r_id         <= n_id;
            r_type       <= n_type;
            r_cur        <= n_cur;
            r_alloc      <= n_alloc;
            r_props      <= n_props;
            r_halted     <= n_halted;
        end
    end

endmodule

/* rtl/odlp_result_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odlp_result_fifo
// Result queue that takes up to two results per cycle and hands out one
// transaction per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module odlp_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_push_cnt,
    input  odlp_pkg::t_out_item i_push0,
    input  odlp_pkg::t_out_item i_push1,
    output logic                o_room,
    output logic                o_valid,
    output odlp_pkg::t_out_item o_data,
    input  logic                i_stall
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

    odlp_pkg::t_out_item r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] v_wr1;
    logic [PW-1:0] v_wr2;
    logic          v_pop;

    // Advance pointers and occupancy
    always_comb begin
        v_wr1   = (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
        v_wr2   = (v_wr1 == PTR_LAST) ? '0 : v_wr1 + PW'(1);
        v_pop   = o_valid && !i_stall;
        n_rd    = v_pop ? ((r_rd == PTR_LAST) ? '0 : r_rd + PW'(1)) : r_rd;
        n_wr    = (i_push_cnt == 2'd2) ? v_wr2 : ((i_push_cnt == 2'd1) ? v_wr1 : r_wr);
        n_count = r_count + CW'(i_push_cnt) - CW'(v_pop);
    end

    assign o_room  = (r_count <= ROOM_LIMIT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // Write incoming results
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[v_wr1] <= i_push1;
        end
    end

    // Hold queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/object_directory_listing_parser_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_directory_listing_parser_unit
// Byte-serial parser for an object directory listing: emits name bytes,
// one record per entry, errors and a done result on the last byte.
// ----------------------------------------------------------------------------
// The unit takes one listing byte per cycle unless the input stalls. A byte
// is captured in an input register and parsed there; its results (none, one,
// or two when a name byte or record is followed by the truncation error or
// done result of the marked last byte) go into a QUEUE_DEPTH-entry result
// queue, from which they leave in order. The output channel moves one result
// transaction per cycle while it is not stalled, so a byte with two results
// costs two output transactions; the input stalls only while the queue holds
// more than QUEUE_DEPTH-2 results. After an error the unit drops bytes
// silently until the marked last byte, which rearms it for a new listing.
module object_directory_listing_parser_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  odlp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output odlp_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    odlp_pkg::t_in_item r_in;
    logic               v_room;
    logic               v_fire;
    logic               v_accept;
    logic [1:0]         v_res_cnt;
    odlp_pkg::t_out_item v_res0;
    odlp_pkg::t_out_item v_res1;

    assign v_fire     = r_in_valid && v_room;
    assign o_in_stall = r_in_valid && !v_room;
    assign v_accept   = i_in_valid && !o_in_stall;

    // Capture the incoming transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (v_accept) begin
            r_in_valid <= 1'b1;
        end else if (v_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_accept) begin
            r_in <= i_in_data;
        end
    end

    odlp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (v_fire),
        .i_item    (r_in),
        .o_res_cnt (v_res_cnt),
        .o_res0    (v_res0),
        .o_res1    (v_res1)
    );

    odlp_result_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_result_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (v_res_cnt),
        .i_push0    (v_res0),
        .i_push1    (v_res1),
        .o_room     (v_room),
        .o_valid    (o_out_valid),
        .o_data     (o_out_data),
        .i_stall    (i_out_stall)
    );

endmodule

/* rtl/odlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odlp_checker
// Port-level checks of the listing parser's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module odlp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input odlp_pkg::t_out_item i_out_data
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Name byte field is only used by name transactions
    a_name_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind != odlp_pkg::KIND_NAME
        |-> i_out_data.name_char == 8'd0)
        else $error("name byte set outside a name transaction");

    // Errors carry a known nonzero status, other kinds carry none
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
        ((i_out_data.kind == odlp_pkg::KIND_ERROR) &&
         (i_out_data.status != odlp_pkg::ST_OK) &&
         (i_out_data.status <= odlp_pkg::ST_TRUNC)) ||
        ((i_out_data.kind != odlp_pkg::KIND_ERROR) &&
         (i_out_data.status == odlp_pkg::ST_OK)))
        else $error("status does not match result kind");

    // Absent sizes read as all ones in a record
    a_absent_sizes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.kind == odlp_pkg::KIND_RECORD
        |-> (i_out_data.has_used_size || i_out_data.used_size == '1) &&
            (i_out_data.has_capacity || i_out_data.capacity == '1))
        else $error("absent size field not all ones");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

endmodule

bind object_directory_listing_parser_unit odlp_checker u_odlp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);

/* tb/odlp_listing_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odlp_listing_checker
// Watches both channels of the directory listing parser, keeps its own
// parser state, predicts the results of every accepted byte and compares
// each result transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module odlp_listing_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  odlp_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  odlp_pkg::t_out_item i_out_data,
    output int                  o_error_count,
    output int                  o_pending,
    output int                  o_parsed_count
);

    // Parser state mirror
    logic [3:0]  phase;
    logic [7:0]  entry_cnt;
    logic [2:0]  field_cnt;
    logic [7:0]  entry_size;
    logic [7:0]  flags;
    logic [6:0]  name_left;
    logic [6:0]  name_total;
    logic [47:0] obj_id;
    logic [15:0] obj_type;
    logic [31:0] cur_size;
    logic [31:0] alloc_size;
    logic [31:0] props;
    logic        halted;

    odlp_pkg::t_out_item pending_results[$];
    int                  error_total  = 0;
    int                  parsed_total = 0;

    // Go back to the start of a listing
    task automatic restart_listing();
        phase     = odlp_pkg::PH_LEN_LO;
        entry_cnt = '0;
        field_cnt = '0;
        halted    = 1'b0;
    endtask

    task automatic reset_parser();
        restart_listing();
        entry_size = '0;
        flags      = '0;
        name_left  = '0;
        name_total = '0;
        obj_id     = '0;
        obj_type   = '0;
        cur_size   = '1;
        alloc_size = '1;
        props      = '0;
    endtask

    function automatic odlp_pkg::t_out_item blank_result(input logic [1:0] kind);
        odlp_pkg::t_out_item res;
        res      = '0;
        res.kind = kind;
        return res;
    endfunction

    // Smallest optional field after the given one whose flag is set
    function automatic logic [3:0] following_field(input logic [3:0] from);
        logic [3:0] nxt;
        nxt = odlp_pkg::PH_SKIP;
        for (int p = int'(odlp_pkg::PH_PROPS); p > int'(from); p--) begin
            if (flags[p - int'(odlp_pkg::PH_TYPE)]) begin
                nxt = 4'(p);
            end
        end
        return nxt;
    endfunction

    function automatic logic [2:0] field_span(input logic [3:0] ph);
        logic [2:0] span;
        case (ph) inside
            odlp_pkg::PH_TYPE: begin
                span = odlp_pkg::TYPE_LEN;
            end
            odlp_pkg::PH_FIRST, odlp_pkg::PH_LAST: begin
                span = odlp_pkg::DATE_LEN;
            end
            default: begin
                span = odlp_pkg::SIZE_LEN;
            end
        endcase
        return span;
    endfunction

    // Advance the parser by one byte and queue the results it causes
    task automatic parse_listing_byte(input odlp_pkg::t_in_item item);
        logic [7:0]          b;
        logic                last;
        logic [2:0]          err;
        logic                entry_done;
        logic [5:0]          sh;
        logic [15:0]         len;
        odlp_pkg::t_out_item res;
        b          = item.data_byte;
        last       = item.last_byte;
        err        = odlp_pkg::ST_OK;
        entry_done = 1'b0;
        sh         = {field_cnt, 3'b000};

        // Drop bytes after an error until the marked last byte
        if (halted) begin
            if (last) begin
                restart_listing();
            end
            return;
        end

        if (phase >= odlp_pkg::PH_ID && phase <= odlp_pkg::PH_PROPS &&
            entry_cnt >= entry_size) begin
            err = odlp_pkg::ST_OVERRUN;
        end

        if (err == odlp_pkg::ST_OK) begin
            case (phase)
                odlp_pkg::PH_LEN_LO: begin
                    obj_id     = '0;
                    obj_type   = '0;
                    cur_size   = '1;
                    alloc_size = '1;
                    props      = '0;
                    flags      = '0;
                    name_total = '0;
                    entry_size = b;
                    entry_cnt  = '0;
                    phase      = odlp_pkg::PH_LEN_HI;
                end
                odlp_pkg::PH_LEN_HI: begin
                    len = {b, entry_size};
                    if (len < odlp_pkg::ENTRY_MIN_LEN || len > odlp_pkg::ENTRY_MAX_LEN) begin
                        err = odlp_pkg::ST_BAD_LEN;
                    end else begin
                        entry_size = len[7:0];
                        field_cnt  = '0;
                        phase      = odlp_pkg::PH_ID;
                    end
                end
                odlp_pkg::PH_ID: begin
                    obj_id    = obj_id | (48'(b) << sh);
                    field_cnt = field_cnt + 3'd1;
                    if (field_cnt >= odlp_pkg::ID_LEN) begin
                        phase = odlp_pkg::PH_NAMELEN;
                    end
                end
                odlp_pkg::PH_NAMELEN: begin
                    if (b < 8'd1 || b > odlp_pkg::NAME_MAX_LEN) begin
                        err = odlp_pkg::ST_BAD_NAME;
                    end else begin
                        name_left  = b[6:0];
                        name_total = b[6:0];
                        phase      = odlp_pkg::PH_NAME;
                    end
                end
                odlp_pkg::PH_NAME: begin
                    res           = blank_result(odlp_pkg::KIND_NAME);
                    res.name_char = b;
                    pending_results.push_back(res);
                    name_left = name_left - 7'd1;
                    if (name_left == '0) begin
                        phase = odlp_pkg::PH_FLAGS;
                    end
                end
                odlp_pkg::PH_FLAGS: begin
                    flags = b;
                    if (b[0]) begin
                        err = odlp_pkg::ST_UUID128;
                    end else begin
                        field_cnt = '0;
                        phase     = odlp_pkg::PH_TYPE;
                    end
                end
                odlp_pkg::PH_SKIP: begin
                end
                default: begin
                    // Optional fields, little-endian; size fields start from all ones
                    if (phase == odlp_pkg::PH_TYPE) begin
                        obj_type = obj_type | (16'(b) << sh);
                    end else if (phase == odlp_pkg::PH_CUR) begin
                        cur_size = (field_cnt == '0) ? 32'(b) : (cur_size | (32'(b) << sh));
                    end else if (phase == odlp_pkg::PH_ALLOC) begin
                        alloc_size = (field_cnt == '0) ? 32'(b) :
                                     (alloc_size | (32'(b) << sh));
                    end else if (phase == odlp_pkg::PH_PROPS) begin
                        props = props | (32'(b) << sh);
                    end
                    field_cnt = field_cnt + 3'd1;
                    if (field_cnt >= field_span(phase)) begin
                        field_cnt = '0;
                        phase     = following_field(phase);
                        if (phase == odlp_pkg::PH_SKIP) begin
                            entry_done = 1'b1;
                        end
                    end
                end
            endcase
            if (err == odlp_pkg::ST_OK) begin
                entry_cnt = entry_cnt + 8'd1;
            end
        end

        // Halt on error; an error on the last byte rearms instead
        if (err != odlp_pkg::ST_OK) begin
            res        = blank_result(odlp_pkg::KIND_ERROR);
            res.status = err;
            pending_results.push_back(res);
            if (last) begin
                restart_listing();
            end else begin
                halted = 1'b1;
            end
            return;
        end

        if (entry_done) begin
            res                   = blank_result(odlp_pkg::KIND_RECORD);
            res.object_id         = obj_id;
            res.object_type       = obj_type;
            res.used_size         = cur_size;
            res.has_used_size     = flags[1];
            res.capacity          = alloc_size;
            res.has_capacity      = flags[2];
            res.object_properties = props;
            res.name_size         = name_total;
            pending_results.push_back(res);
        end
        if (phase == odlp_pkg::PH_SKIP && entry_cnt >= entry_size) begin
            phase = odlp_pkg::PH_LEN_LO;
        end

        if (last) begin
            if (phase == odlp_pkg::PH_LEN_LO || phase == odlp_pkg::PH_SKIP) begin
                res = blank_result(odlp_pkg::KIND_DONE);
            end else begin
                res        = blank_result(odlp_pkg::KIND_ERROR);
                res.status = odlp_pkg::ST_TRUNC;
            end
            pending_results.push_back(res);
            restart_listing();
        end
    endtask

    function automatic int field_differs(input string fname, input logic [63:0] want,
                                         input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic int result_mismatches(input odlp_pkg::t_out_item want,
                                             input odlp_pkg::t_out_item got);
        int bad;
        bad = 0;
        bad += field_differs("kind", want.kind, got.kind);
        bad += field_differs("name_char", want.name_char, got.name_char);
        bad += field_differs("object_id", want.object_id, got.object_id);
        bad += field_differs("object_type", want.object_type, got.object_type);
        bad += field_differs("used_size", want.used_size, got.used_size);
        bad += field_differs("has_used_size", want.has_used_size, got.has_used_size);
        bad += field_differs("capacity", want.capacity, got.capacity);
        bad += field_differs("has_capacity", want.has_capacity, got.has_capacity);
        bad += field_differs("object_properties", want.object_properties,
                             got.object_properties);
        bad += field_differs("name_size", want.name_size, got.name_size);
        bad += field_differs("status", want.status, got.status);
        return bad;
    endfunction

    // Compare result transactions, then predict the accepted byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            pending_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: kind 0x%0h", i_out_data.kind);
                    error_total++;
                end else begin
                    error_total += result_mismatches(pending_results.pop_front(),
                                                     i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parsed_total++;
                parse_listing_byte(i_in_data);
            end
        end
        o_error_count  <= error_total;
        o_pending      <= pending_results.size();
        o_parsed_count <= parsed_total;
    end

endmodule

/* tb/object_directory_listing_parser_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_directory_listing_parser_unit_test
// Feeds directory listings to the parser: a few hand-made byte sequences,
// then random listings, mostly well-formed, some broken or truncated, some
// plain noise. Random gaps on the input and stalls on the output; a checker
// beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module object_directory_listing_parser_unit_test;

    localparam int ITEM_TARGET    = 1850;
    localparam int HOLD_CYCLES    = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PAUSE_EVERY    = 40;

    // Flag bits of an entry
    localparam int FLAG_UUID128 = 0;
    localparam int FLAG_CUR     = 1;
    localparam int FLAG_ALLOC   = 2;
    localparam int FLAG_FIRST   = 3;
    localparam int FLAG_LAST    = 4;
    localparam int FLAG_PROPS   = 5;

    // Ways to break an entry
    localparam int BRK_NONE    = 0;
    localparam int BRK_LENGTH  = 1;
    localparam int BRK_NAME    = 2;
    localparam int BRK_OVERRUN = 3;
    localparam int BRK_UUID    = 4;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    odlp_pkg::t_in_item  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    odlp_pkg::t_out_item o_out_data;

    int         error_count;
    int         pending;
    int         parsed_count;
    int         idle_cycles   = 0;
    int         hold_requests = 0;
    int         holds_served  = 0;
    logic       quiet         = 1'b0;
    logic [7:0] listing_bytes[$];

    always #1 i_clk = ~i_clk;

    object_directory_listing_parser_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    odlp_listing_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_data     (o_out_data),
        .o_error_count  (error_count),
        .o_pending      (pending),
        .o_parsed_count (parsed_count)
    );

    // End the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end
        if (r < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    // Hold the output stalled, then release it; n, at least one, sets how long
    task automatic stall_output(input int n);
        @(negedge i_clk);
        i_out_stall <= 1'b1;
        repeat (n) @(negedge i_clk);
        i_out_stall <= 1'b0;
    endtask

    // Receiver: random stalls, a long hold on request, none while quiet
    initial begin
        i_out_stall = 1'b0;
        forever begin
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                stall_output(HOLD_CYCLES);
            end else if (quiet) begin
                @(negedge i_clk);
            end else begin
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
                stall_output(stall_len());
            end
        end
    end

    // Offer one byte after a random gap and wait for its transaction
    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= {value, last};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Send the built listing, minus a tail of drop bytes, marking its last byte
    task automatic send_listing(input int drop);
        int n;
        n = listing_bytes.size() - drop;
        for (int k = 0; k < n; k++) begin
            send_byte(listing_bytes[k], k == n - 1);
        end
    endtask

    // Stop offering until every predicted result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic int entry_span(input int name_bytes, input logic [7:0] flags);
        int span;
        span = 2 + int'(odlp_pkg::ID_LEN) + 1 + name_bytes + 1 + int'(odlp_pkg::TYPE_LEN);
        if (flags[FLAG_CUR])   span += int'(odlp_pkg::SIZE_LEN);
        if (flags[FLAG_ALLOC]) span += int'(odlp_pkg::SIZE_LEN);
        if (flags[FLAG_FIRST]) span += int'(odlp_pkg::DATE_LEN);
        if (flags[FLAG_LAST])  span += int'(odlp_pkg::DATE_LEN);
        if (flags[FLAG_PROPS]) span += int'(odlp_pkg::SIZE_LEN);
        return span;
    endfunction

    // Append one entry; a negative declared length means the true length
    task automatic add_entry(input int name_len, input logic [7:0] flags, input int trail,
                             input int declared);
        int          name_bytes;
        int          span;
        logic [15:0] len;
        name_bytes = (name_len < 1 || name_len > int'(odlp_pkg::NAME_MAX_LEN)) ?
                     2 : name_len;
        span       = entry_span(name_bytes, flags);
        len        = (declared < 0) ? 16'(span + trail) : 16'(declared);
        listing_bytes.push_back(len[7:0]);
        listing_bytes.push_back(len[15:8]);
        repeat (int'(odlp_pkg::ID_LEN)) listing_bytes.push_back(8'($urandom));
        listing_bytes.push_back(8'(name_len));
        repeat (name_bytes) listing_bytes.push_back(8'($urandom));
        listing_bytes.push_back(flags);
        repeat (span + trail - (10 + name_bytes)) listing_bytes.push_back(8'($urandom));
    endtask

    function automatic logic [7:0] random_flags();
        return 8'($urandom) & ~(8'd1 << FLAG_UUID128);
    endfunction

    // Append a random entry, well-formed or broken in the given way
    task automatic add_random_entry(input int breakage);
        int         r;
        int         name_len;
        int         trail;
        int         declared;
        logic [7:0] flags;
        r        = $urandom_range(0, 99);
        flags    = random_flags();
        trail    = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, 5);
        declared = -1;
        if (r < 3) begin
            // Largest entry: longest name, every field, padded to the maximum length
            name_len = int'(odlp_pkg::NAME_MAX_LEN);
            flags    = flags | 8'h3E;
            trail    = int'(odlp_pkg::ENTRY_MAX_LEN) - entry_span(name_len, flags);
        end else if (r < 8) begin
            name_len = $urandom_range(0, 1) ? 1 : int'(odlp_pkg::NAME_MAX_LEN);
        end else if (r < 18) begin
            name_len = $urandom_range(13, int'(odlp_pkg::NAME_MAX_LEN));
        end else begin
            name_len = $urandom_range(1, 12);
        end
        case (breakage)
            BRK_LENGTH: begin
                case ($urandom_range(0, 4))
                    0: declared = int'(odlp_pkg::ENTRY_MIN_LEN) - 1;
                    1: declared = int'(odlp_pkg::ENTRY_MAX_LEN) + 1;
                    2: declared = $urandom_range(0, 11);
                    3: declared = $urandom_range(174, 255);
                    default: declared = $urandom_range(256, 65535);
                endcase
            end
            BRK_NAME: begin
                case ($urandom_range(0, 2))
                    0: name_len = 0;
                    1: name_len = int'(odlp_pkg::NAME_MAX_LEN) + 1;
                    default: name_len = $urandom_range(122, 255);
                endcase
            end
            BRK_OVERRUN: begin
                name_len = $urandom_range(10, 40);
                declared = $urandom_range(int'(odlp_pkg::ENTRY_MIN_LEN),
                                          entry_span(name_len, flags) + trail - 1);
            end
            BRK_UUID: begin
                flags[FLAG_UUID128] = 1'b1;
            end
            default: begin
            end
        endcase
        add_entry(name_len, flags, trail, declared);
    endtask

    // One random listing: well-formed, broken, truncated or noise
    task automatic random_listing();
        int r;
        int entries;
        int drop;
        listing_bytes.delete();
        quiet = ($urandom_range(0, 5) == 0);
        r     = $urandom_range(0, 99);
        drop  = 0;
        if (r < 8) begin
            repeat ($urandom_range(1, 24)) listing_bytes.push_back(8'($urandom));
        end else begin
            entries = $urandom_range(1, 4);
            for (int k = 0; k < entries; k++) begin
                add_random_entry((r >= 72 && k == entries - 1) ?
                                 $urandom_range(BRK_LENGTH, BRK_UUID) : BRK_NONE);
            end
            if (r >= 72 && $urandom_range(0, 1)) begin
                add_random_entry(BRK_NONE);
            end
            if (r >= 60 && r < 72) begin
                drop = $urandom_range(1, listing_bytes.size() - 1);
            end
        end
        send_listing(drop);
    endtask

    // Stimulus and verdict
    initial begin
        int listings;
        listings   = 0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Smallest entry, all-ones id, record and done on the same last byte
        listing_bytes = '{8'd13, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          8'd1, 8'h41, 8'h00, 8'h00, 8'hFF};
        send_listing(0);
        // Too short a length, error on the last byte
        listing_bytes = '{8'd12, 8'h00};
        send_listing(0);
        // Length with high byte set, then dropped bytes up to the last one
        listing_bytes = '{8'hFF, 8'hFF, 8'hA5, 8'h00};
        send_listing(0);
        // Listing that ends on its first byte
        listing_bytes = '{8'h0D};
        send_listing(0);

        // Hold the output while long names keep coming, so the block backs up
        hold_requests++;
        quiet = 1'b1;
        listing_bytes.delete();
        repeat (3) add_entry($urandom_range(40, 80), random_flags(), 0, -1);
        send_listing(0);
        wait_drained();

        while (parsed_count < ITEM_TARGET) begin
            random_listing();
            listings++;
            if (listings % PAUSE_EVERY == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/odlp_pkg.sv
rtl/odlp_parser.sv
rtl/odlp_result_fifo.sv
rtl/object_directory_listing_parser_unit.sv
rtl/odlp_checker.sv
tb/odlp_listing_checker.sv
tb/object_directory_listing_parser_unit_test.sv
